FILE: hw/rtl/clip_playback_fade_controller_macros.svh
// ----------------------------------------------------------------------------
// Clip playback fade controller assertion macros
// Shared concurrent check forms for the fade controller RTL.
// ----------------------------------------------------------------------------
`ifndef CLIP_PLAYBACK_FADE_CONTROLLER_MACROS_SVH
`define CLIP_PLAYBACK_FADE_CONTROLLER_MACROS_SVH

// Same-cycle implication under reset.
`define CPFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under reset.
`define CPFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/cpfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clip playback fade controller package
// Phase codes, sequencer states, register indexes and shared widths.
// ----------------------------------------------------------------------------
package cpfc_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int DIV_W             = 64;
	localparam int DIV_CNT_W         = $clog2(DIV_W);
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 24;

	typedef enum logic [2:0] {
		PH_OFF        = 3'd0,
		PH_START_UP   = 3'd1,
		PH_UP         = 3'd2,
		PH_RUN        = 3'd3,
		PH_START_DOWN = 3'd4,
		PH_DOWN       = 3'd5,
		PH_FINISHED   = 3'd6
	} phase_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PRE,
		S_MUL1,
		S_MUL2,
		S_DIV_DM,
		S_DIV_STEP,
		S_MUL_SW,
		S_DIV_SW,
		S_DIV_RDN,
		S_AREA,
		S_MUL_TLO,
		S_MUL_THI,
		S_TACC,
		S_WT_CHK,
		S_DIV_WT,
		S_WRAP
	} seq_t;

	localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMM_FADE_IN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMM_FADE_OUT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_IN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED        = 3'd5;

	localparam logic [15:0] SPEED_RESET = 16'd256;

endpackage

FILE: hw/rtl/clip_playback_fade_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clip playback fade controller
// Fade phase machine, fade weight and normalized play position per tick.
// ----------------------------------------------------------------------------
// Early end: a tick that is off with no trigger, or finished with no restart,
//   goes from the phase update straight to the result state.
// Throughput: one item at a time; the rate is set by up to five divisions
//   through the single shared radix-2 divider.
// Reset: arst_n clears phase to off, weight, position and the ramp-down guard
//   to zero and loads the configuration registers with their reset values.
module clip_playback_fade_controller
	import cpfc_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	localparam int OUT_BITS = 3 + 2 * (FRACTION_BITS + 1) + 3,
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// time_delta[19:0], trigger_active[20], speed_factor[36:21],
	// clip_duration[68:37], queued_duration[100:69], zero pad to 104
	input  logic [103:0]          s_tdata,
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// phase, fade_weight, play_position, switched_clip, wrapped_at_start,
	// wrapped_at_end, from bit 0 up, zero pad to whole bytes
	output logic [OUT_W-1:0]      m_tdata
);

	localparam int FB        = FRACTION_BITS;
	localparam int PW        = FB + 9;            // signed working position
	localparam int DMW       = FB + 7;            // saturated delta magnitude
	localparam int UP_SHIFT  = (FB >= 16) ? (FB - 16) : 0;
	localparam int DN_SHIFT  = (FB < 16) ? (16 - FB) : 0;
	localparam logic [DIV_W-1:0]     QONE   = DIV_W'(1) << FB;
	localparam logic [DIV_W-1:0]     DCAP   = DIV_W'(64) << FB;
	localparam logic signed [PW-1:0] QPOS   = PW'(1) << FB;
	localparam logic [FB:0]          WFULL  = (FB + 1)'(1) << FB;

	// configuration
	logic        loop_q, ifi_q, ifo_q;
	logic [23:0] fin_q, fout_q;
	logic [15:0] speed_q;

	// tick state
	phase_t      phase_q;
	logic [FB:0] weight_q;
	logic [FB:0] position_q;
	logic        guard_q;

	// per-item working registers
	seq_t               state_q, state_d;
	logic [19:0]        dt_q;
	logic               trig_q;
	logic [15:0]        sf_q;
	logic [31:0]        dur_q;
	logic [31:0]        qd_q;
	logic               neg_q;
	logic [63:0]        mul_q;
	logic signed [PW-1:0] pos_q;
	logic [DIV_W-1:0]   step_q;
	logic [DIV_W-1:0]   rampq_q;
	logic [DIV_W-1:0]   rdn_q;
	logic [DIV_W-1:0]   tin_q;
	logic               sw_q, ws_q, we_q;
	logic               div_run_q;
	logic               pre_early_q;
	logic               out_fresh_q;

	// shared units
	logic [31:0]      mul_a, mul_b;
	logic             div_start, div_busy, div_done;
	logic [DIV_W-1:0] div_num, div_den, div_quo;

	cpfc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	// ------------------------------------------------------------------
	// Phase update at the head of a tick
	// ------------------------------------------------------------------
	phase_t pre_phase, pre_mid;
	logic   pre_early;
	logic   pre_guard;
	logic   pre_pos_clr;

	always_comb begin
		pre_mid     = phase_q;
		pre_early   = 1'b0;
		pre_guard   = 1'b0;
		pre_pos_clr = 1'b0;
		case (phase_q)
			PH_OFF: begin
				if (!trig_q) begin
					pre_early = 1'b1;
				end else begin
					pre_pos_clr = 1'b1;
					pre_mid     = PH_START_UP;
				end
			end
			PH_START_UP, PH_UP: begin
				pre_mid = PH_UP;
				if (weight_q >= WFULL) begin
					pre_guard = 1'b1;
					pre_mid   = PH_RUN;
				end
			end
			PH_START_DOWN, PH_DOWN: begin
				pre_mid = PH_DOWN;
				if (weight_q == '0) pre_mid = PH_FINISHED;
				if (trig_q && ifi_q && loop_q) pre_mid = PH_START_UP;
			end
			PH_FINISHED: begin
				if (trig_q && ifi_q) begin
					pre_mid = PH_START_UP;
				end else begin
					pre_mid   = PH_OFF;
					pre_early = 1'b1;
				end
			end
			default: ;
		endcase
		pre_phase = pre_mid;
		if (!pre_early && pre_mid == PH_RUN && !trig_q && ifo_q) pre_phase = PH_START_DOWN;
	end

	// ------------------------------------------------------------------
	// Combinational helpers for the datapath states
	// ------------------------------------------------------------------
	logic [15:0]      ps_abs;
	logic [DMW-1:0]   dm_sat;
	logic signed [PW-1:0] pos_base;
	logic             sw_take;
	logic signed [65:0] pos_x, rdn_x, step_x, lim_x, tin_x;
	logic             area;
	logic             ramp_down_now;
	logic             up_ph, down_ph, wt_div;
	logic [DIV_W-1:0] w_room;
	logic signed [PW-1:0] pos_m1;
	logic [FB:0]      wrap_hi, wrap_lo;

	assign ps_abs   = speed_q[15] ? 16'(-speed_q) : speed_q;
	assign dm_sat   = (div_quo > DCAP) ? DMW'(DCAP) : div_quo[DMW-1:0];
	assign pos_base = $signed(PW'({1'b0, position_q}));
	assign sw_take  = (pos_q > QPOS) && (qd_q != '0);

	// fade-out window test: forward runs look at the tail, reverse at the head
	always_comb begin
		pos_x  = 66'(pos_q);
		rdn_x  = $signed({2'b00, rdn_q});
		step_x = $signed({2'b00, step_q});
		if (!neg_q) begin
			area  = (pos_x + rdn_x) > $signed({2'b00, QONE});
			lim_x = pos_x + rdn_x - $signed({2'b00, QONE});
		end else begin
			area  = pos_x < rdn_x;
			lim_x = rdn_x - pos_x;
		end
		tin_x = (step_x < lim_x) ? step_x : lim_x;
	end

	assign ramp_down_now = !trig_q && area && (!loop_q || !guard_q);

	assign up_ph   = (phase_q == PH_START_UP) || (phase_q == PH_UP);
	assign down_ph = (phase_q == PH_START_DOWN) || (phase_q == PH_DOWN);
	assign wt_div  = (up_ph && weight_q < WFULL && fin_q != '0) ||
	                 (down_ph && weight_q != '0 && fout_q != '0);
	assign w_room  = QONE - DIV_W'(weight_q);

	assign pos_m1  = pos_q - PW'(1);
	assign wrap_hi = {1'b0, pos_m1[FB-1:0]} + (FB + 1)'(1);
	assign wrap_lo = {1'b0, pos_q[FB-1:0]};

	// ------------------------------------------------------------------
	// Sequencer: next state and unit operand selection
	// ------------------------------------------------------------------
	logic in_div;

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		div_num  = '0;
		div_den  = DIV_W'(1);
		in_div   = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = S_PRE;
			end
			S_PRE: state_d = pre_early ? S_WRAP : S_MUL1;
			S_MUL1: begin
				mul_a   = 32'(ps_abs);
				mul_b   = 32'(sf_q);
				state_d = S_MUL2;
			end
			S_MUL2: begin
				mul_a   = mul_q[31:0];
				mul_b   = 32'(dt_q);
				state_d = S_DIV_DM;
			end
			S_DIV_DM: begin
				in_div  = 1'b1;
				div_num = mul_q << UP_SHIFT;
				div_den = DIV_W'(dur_q) << DN_SHIFT;
				if (div_done) state_d = S_DIV_STEP;
			end
			S_DIV_STEP: begin
				in_div  = 1'b1;
				div_num = DIV_W'(dt_q) << FB;
				div_den = DIV_W'(dur_q);
				if (div_done) begin
					if (sw_take) state_d = S_MUL_SW;
					else if (phase_q == PH_RUN) state_d = S_DIV_RDN;
					else state_d = S_WT_CHK;
				end
			end
			S_MUL_SW: begin
				mul_a   = 32'(pos_q);
				mul_b   = dur_q;
				state_d = S_DIV_SW;
			end
			S_DIV_SW: begin
				in_div  = 1'b1;
				div_num = mul_q;
				div_den = DIV_W'(qd_q);
				if (div_done) state_d = (phase_q == PH_RUN) ? S_DIV_RDN : S_WT_CHK;
			end
			S_DIV_RDN: begin
				in_div  = 1'b1;
				div_num = DIV_W'(fout_q) << FB;
				div_den = DIV_W'(dur_q);
				if (div_done) state_d = S_AREA;
			end
			S_AREA: state_d = ramp_down_now ? S_MUL_TLO : S_WT_CHK;
			S_MUL_TLO: begin
				mul_a   = tin_q[31:0];
				mul_b   = dur_q;
				state_d = S_MUL_THI;
			end
			S_MUL_THI: begin
				mul_a   = tin_q[63:32];
				mul_b   = dur_q;
				state_d = S_TACC;
			end
			S_TACC: state_d = S_WT_CHK;
			S_WT_CHK: state_d = wt_div ? S_DIV_WT : S_WRAP;
			S_DIV_WT: begin
				in_div  = 1'b1;
				div_num = rampq_q;
				div_den = up_ph ? DIV_W'(fin_q) : DIV_W'(fout_q);
				if (div_done) state_d = S_WRAP;
			end
			S_WRAP: begin
				// wrap pass on the first cycle; present the result after it, hold until taken
				m_tvalid = !out_fresh_q;
				if (m_tready && !out_fresh_q) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign div_start = in_div && !div_run_q && !div_busy;

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	logic wrap_pass;

	// the wrap/clamp pass runs once, on entry to the result state
	assign wrap_pass = (state_q == S_WRAP) && out_fresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_run_q   <= 1'b0;
			out_fresh_q <= 1'b0;
			loop_q      <= 1'b0;
			ifi_q       <= 1'b0;
			ifo_q       <= 1'b0;
			fin_q       <= '0;
			fout_q      <= '0;
			speed_q     <= SPEED_RESET;
			phase_q     <= PH_OFF;
			weight_q    <= '0;
			position_q  <= '0;
			guard_q     <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_fresh_q <= (state_q != S_WRAP) && (state_d == S_WRAP);
			if (div_start) div_run_q <= 1'b1;
			else if (div_done) div_run_q <= 1'b0;

			if (cfg_wen) begin
				case (cfg_index)
					REG_LOOP_ENABLE:  loop_q  <= cfg_wdata[0];
					REG_IMM_FADE_IN:  ifi_q   <= cfg_wdata[0];
					REG_IMM_FADE_OUT: ifo_q   <= cfg_wdata[0];
					REG_FADE_IN:      fin_q   <= cfg_wdata;
					REG_FADE_OUT:     fout_q  <= cfg_wdata;
					REG_SPEED:        speed_q <= cfg_wdata[15:0];
					default: ;
				endcase
			end

			case (state_q)
				S_PRE: begin
					phase_q <= pre_phase;
					if (pre_guard) guard_q <= 1'b1;
					if (pre_pos_clr) position_q <= '0;
				end
				S_AREA: begin
					if (ramp_down_now) phase_q <= PH_START_DOWN;
					guard_q <= area;
				end
				S_WT_CHK: begin
					// zero fade times jump straight to the end weight
					if (up_ph) begin
						if (weight_q < WFULL && fin_q == '0) weight_q <= WFULL;
						else if (weight_q > WFULL) weight_q <= WFULL;
					end else if (down_ph) begin
						if (weight_q != '0 && fout_q == '0) weight_q <= '0;
					end
				end
				S_DIV_WT: begin
					if (div_done) begin
						if (up_ph) begin
							weight_q <= (div_quo >= w_room) ? WFULL :
							            weight_q + (FB + 1)'(div_quo);
						end else begin
							weight_q <= (div_quo >= DIV_W'(weight_q)) ? '0 :
							            weight_q - (FB + 1)'(div_quo);
						end
					end
				end
				S_WRAP: begin
					if (wrap_pass && !pre_early_q) begin
						if (loop_q) begin
							if (pos_q > QPOS) begin
								position_q <= wrap_hi;
								guard_q    <= 1'b0;
							end else if (pos_q < 0) begin
								position_q <= wrap_lo;
								guard_q    <= 1'b0;
							end else begin
								position_q <= pos_q[FB:0];
							end
						end else begin
							if (pos_q > QPOS) position_q <= QPOS[FB:0];
							else if (pos_q < 0) position_q <= '0;
							else position_q <= pos_q[FB:0];
						end
					end
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					dt_q   <= s_tdata[19:0];
					trig_q <= s_tdata[20];
					sf_q   <= s_tdata[36:21];
					// a zero duration counts as one microsecond
					dur_q  <= (s_tdata[68:37] == '0) ? 32'd1 : s_tdata[68:37];
					qd_q   <= s_tdata[100:69];
				end
			end
			S_PRE: begin
				pre_early_q <= pre_early;
				neg_q       <= speed_q[15] && (sf_q != '0);
				rampq_q     <= DIV_W'(dt_q) << FB;
				sw_q        <= 1'b0;
				ws_q        <= 1'b0;
				we_q        <= 1'b0;
			end
			S_MUL1, S_MUL2, S_MUL_SW, S_MUL_TLO, S_MUL_THI: begin
				mul_q <= 64'(mul_a) * 64'(mul_b);
				if (state_q == S_MUL_THI) rampq_q <= mul_q;
			end
			S_DIV_DM: begin
				if (div_done) begin
					pos_q <= neg_q ? pos_base - $signed(PW'(dm_sat))
					               : pos_base + $signed(PW'(dm_sat));
				end
			end
			S_DIV_STEP: begin
				if (div_done) begin
					step_q <= div_quo;
					// overrun with a queued clip: hand over to it
					if (sw_take) begin
						pos_q <= pos_q - QPOS;
						sw_q  <= 1'b1;
					end
				end
			end
			S_DIV_SW: begin
				if (div_done) begin
					step_q <= div_quo;
					dur_q  <= qd_q;
				end
			end
			S_DIV_RDN: begin
				if (div_done) rdn_q <= div_quo;
			end
			S_AREA: tin_q <= tin_x[63:0];
			S_TACC: rampq_q <= rampq_q + {mul_q[31:0], 32'd0};
			S_WRAP: begin
				if (wrap_pass && !pre_early_q && loop_q) begin
					if (pos_q > QPOS) we_q <= 1'b1;
					else if (pos_q < 0) ws_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign m_tdata = OUT_W'({we_q, ws_q, sw_q, position_q, weight_q, phase_q});

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`include "clip_playback_fade_controller_macros.svh"

	`CPFC_ASSERT_NOW(a_one_side, clk, arst_n, m_tvalid, !s_tready, "accept while result pending")
	`CPFC_ASSERT_NOW(a_weight_max, clk, arst_n, 1'b1, weight_q <= WFULL, "weight above full")
	`CPFC_ASSERT_NOW(a_pos_max, clk, arst_n, 1'b1, position_q <= WFULL, "position past end")
	`CPFC_ASSERT_NOW(a_div_idle, clk, arst_n, div_start, !div_busy, "divider restarted busy")
	`CPFC_ASSERT_NEXT(a_accept_pre, clk, arst_n, s_tvalid && s_tready, state_q == S_PRE,
		"accepted item did not enter head of tick")

endmodule

FILE: hw/rtl/cpfc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fade controller shared divider
// Radix-2 restoring divider, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module cpfc_div
	import cpfc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] num,
	input  logic [DIV_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [DIV_W-1:0] quo
);

	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_W:0]       trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			// shift in one numerator bit, subtract when the divisor fits
			rem_q <= fits ? DIV_W'(trial - {1'b0, den_q}) : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule
